/* rtl/core/prefix_reversal_flip_counter_macros.svh */
// ----------------------------------------------------------------------------
// prefix reversal flip counter assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PREFIX_REVERSAL_FLIP_COUNTER_MACROS_SVH
`define PREFIX_REVERSAL_FLIP_COUNTER_MACROS_SVH
`ifndef SYNTH
`define PFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfc assertion failed");
`define PFC_ASSERT_IF(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("pfc assertion failed");
`else
`define PFC_ASSERT(lbl, clk, rst_n, prop)
`define PFC_ASSERT_IF(lbl, clk, rst_n, cond, prop)
`endif
`endif

/* rtl/core/pfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int MAX_CARDS = 16;
  localparam int CARD_W    = 8;
  localparam int CFG_W     = 5;
  localparam int COUNT_W   = 16;
  localparam int PERM_W    = 32;
  localparam int IDX_W     = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int CNT_W     = $clog2(MAX_CARDS + 1);

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic cfg_we;
    logic load;
    logic flip;
    logic finish;
  } pfc_cmd_t;

  typedef struct packed {
    logic last_card;
    logic deck_bad;
    logic stop;
  } pfc_stat_t;

endpackage

/* rtl/core/prefix_reversal_flip_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_reversal_flip_counter
// topswops flip counter: loads a deck, counts prefix reversals until card 1
// ----------------------------------------------------------------------------
// Usage:
//   card_i is taken at each edge with start_i high and busy_o low, one card
//   per cycle, filling deck positions 0, 1, 2, ... up to deck_size cards.
//   deck_size is written over the cfg channel (cfg_valid_i / cfg_ready_o,
//   data on cfg_data_i); a write restarts the deck being loaded.
//   After the last card busy_o rises and the block does one reversal per
//   cycle; the single result is shown on done_o for one cycle, set from a
//   register once card 1 is on top or the count saturates. A deck with a bad
//   card reports in the next cycle with flip_count_o = 0 and no busy time.
//   The result cannot be held off by the receiver: done_o is a strobe and
//   the result ports keep their values until the next deck's last card is
//   taken. Reset clears the best count, the permutation number and the
//   load position and sets deck_size to 16.
// ----------------------------------------------------------------------------
module prefix_reversal_flip_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pfc_pkg::CARD_W-1:0]  card_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfc_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic [pfc_pkg::COUNT_W-1:0] flip_count_o,
  output logic                        new_best_o,
  output logic [pfc_pkg::PERM_W-1:0]  perm_number_o,
  output logic                        bad_input_o
);

  pfc_pkg::pfc_cmd_t  cmd;
  pfc_pkg::pfc_stat_t stat;

  pfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .done_o      (done_o)
  );

  pfc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_data_i    (cfg_data_i),
    .card_i        (card_i),
    .stat_o        (stat),
    .flip_count_o  (flip_count_o),
    .new_best_o    (new_best_o),
    .perm_number_o (perm_number_o),
    .bad_input_o   (bad_input_o)
  );

endmodule

/* rtl/core/pfc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ctrl
// load / flip sequencer and result strobe
// ----------------------------------------------------------------------------
`include "prefix_reversal_flip_counter_macros.svh"

module pfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cfg_valid_i,
  input  pfc_pkg::pfc_stat_t stat_i,
  output pfc_pkg::pfc_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              cfg_ready_o,
  output logic              done_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FLIP = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  assign busy_o      = (state_q == ST_FLIP);
  assign cfg_ready_o = ~busy_o;
  assign accept      = start_i & ~busy_o;

  always_comb begin
    cmd_o.cfg_we = cfg_valid_i & cfg_ready_o;
    cmd_o.load   = accept;
    cmd_o.flip   = (state_q == ST_FLIP) & ~stat_i.stop;
    cmd_o.finish = (state_q == ST_FLIP) & stat_i.stop;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.last_card) begin
          // bad deck reports at once, good deck goes flipping
          if (stat_i.deck_bad) begin
            done_d = 1'b1;
          end else begin
            state_d = ST_FLIP;
          end
        end
      end
      ST_FLIP: begin
        if (stat_i.stop) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

  `PFC_ASSERT_IF(a_done_in_idle, clk_i, rst_ni, done_o, state_q == ST_IDLE)
  `PFC_ASSERT_IF(a_busy_after_start, clk_i, rst_ni, $rose(busy_o), $past(start_i))
  `PFC_ASSERT_IF(a_done_source, clk_i, rst_ni, done_o, $past(start_i) || $past(busy_o))

endmodule

/* rtl/core/pfc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_dp
// deck store, prefix reversal network, counters and result registers
// ----------------------------------------------------------------------------
module pfc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfc_pkg::pfc_cmd_t             cmd_i,
  input  logic [pfc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [pfc_pkg::CARD_W-1:0]    card_i,
  output pfc_pkg::pfc_stat_t            stat_o,
  output logic [pfc_pkg::COUNT_W-1:0]   flip_count_o,
  output logic                          new_best_o,
  output logic [pfc_pkg::PERM_W-1:0]    perm_number_o,
  output logic                          bad_input_o
);

  logic [pfc_pkg::CARD_W-1:0]  deck_q [pfc_pkg::MAX_CARDS];
  logic [pfc_pkg::CARD_W-1:0]  deck_flip [pfc_pkg::MAX_CARDS];
  logic [pfc_pkg::CFG_W-1:0]   cfg_q;
  logic [pfc_pkg::CNT_W-1:0]   pos_q, pos_eff;
  logic                        err_q;
  logic [pfc_pkg::COUNT_W-1:0] moves_q, best_q;
  logic                        best_valid_q, new_best_q, bad_q;
  logic [pfc_pkg::PERM_W-1:0]  perm_q;
  logic [pfc_pkg::CARD_W-1:0]  cfg_ext, size, top;
  logic [pfc_pkg::IDX_W-1:0]   top_idx;
  logic                        card_bad;

  // effective deck size, clamped to 1..MAX_CARDS
  always_comb begin
    cfg_ext = pfc_pkg::CARD_W'(cfg_q);
    if (cfg_ext == '0) begin
      size = pfc_pkg::CARD_W'(1);
    end else if (cfg_ext > pfc_pkg::CARD_W'(pfc_pkg::MAX_CARDS)) begin
      size = pfc_pkg::CARD_W'(pfc_pkg::MAX_CARDS);
    end else begin
      size = cfg_ext;
    end
  end

  assign pos_eff  = (pfc_pkg::CARD_W'(pos_q) >= size) ? '0 : pos_q;
  assign card_bad = (card_i == '0) || (card_i > size);
  assign top      = deck_q[0];
  assign top_idx  = pfc_pkg::IDX_W'(top - pfc_pkg::CARD_W'(1));

  always_comb begin
    stat_o.last_card = (pfc_pkg::CARD_W'(pos_eff) + pfc_pkg::CARD_W'(1)) == size;
    stat_o.deck_bad  = err_q | card_bad;
    stat_o.stop      = (top == pfc_pkg::CARD_W'(1)) || (top == '0) || (top > size) ||
                       (moves_q == pfc_pkg::COUNT_MAX);
  end

  // reverse the first top cards
  always_comb begin
    for (int i = 0; i < pfc_pkg::MAX_CARDS; i++) begin
      if (pfc_pkg::CARD_W'(i) < top) begin
        deck_flip[i] = deck_q[top_idx - pfc_pkg::IDX_W'(i)];
      end else begin
        deck_flip[i] = deck_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deck_q[pos_eff[pfc_pkg::IDX_W-1:0]] <= card_i;
    end else if (cmd_i.flip) begin
      deck_q <= deck_flip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= pfc_pkg::CFG_RESET;
      pos_q        <= '0;
      err_q        <= 1'b0;
      moves_q      <= '0;
      best_q       <= '0;
      best_valid_q <= 1'b0;
      new_best_q   <= 1'b0;
      bad_q        <= 1'b0;
      perm_q       <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        // size change restarts the deck being loaded
        cfg_q <= cfg_data_i;
        pos_q <= '0;
        err_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (stat_o.last_card) begin
          pos_q <= '0;
          err_q <= 1'b0;
        end else begin
          pos_q <= pos_eff + pfc_pkg::CNT_W'(1);
          err_q <= stat_o.deck_bad;
        end
      end
      if (cmd_i.load && stat_o.last_card) begin
        perm_q     <= perm_q + pfc_pkg::PERM_W'(1);
        bad_q      <= stat_o.deck_bad;
        moves_q    <= '0;
        new_best_q <= 1'b0;
      end
      if (cmd_i.flip) begin
        moves_q <= moves_q + pfc_pkg::COUNT_W'(1);
      end
      if (cmd_i.finish) begin
        if (!best_valid_q || (moves_q > best_q)) begin
          best_q       <= moves_q;
          best_valid_q <= 1'b1;
          new_best_q   <= 1'b1;
        end else begin
          new_best_q <= 1'b0;
        end
      end
    end
  end

  assign flip_count_o  = moves_q;
  assign new_best_o    = new_best_q;
  assign perm_number_o = perm_q;
  assign bad_input_o   = bad_q;

endmodule
